// ===== hw/rtl/vfc_pkg.sv =====
// ----------------------------------------------------------------------------
// vfc_pkg: frustum cull shared definitions
// Widths, fixed-point constants, opcodes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package vfc_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned W         = 32;
  localparam int unsigned HW        = 31;
  localparam int unsigned MW        = W + 1;
  localparam int unsigned PW        = 2 * MW;
  localparam int unsigned ACC_W     = PW + 32 + 2;
  localparam int unsigned SQ_W      = 2 * W;
  localparam int unsigned DVD_W     = W + FRAC_BITS;
  localparam int unsigned SQ_LAST   = W + 1;
  localparam int unsigned CNT_W     = $clog2(DVD_W + 1);

  localparam logic [W-1:0] LEN_EPS =
    W'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);
  localparam logic [W-1:0] PT_EPS =
    W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [ACC_W-1:0] PT_EPS_ACC = ACC_W'(PT_EPS) << (2 * FRAC_BITS);
  localparam logic signed [MW-1:0] ONE_Q = MW'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_BUILD = 2'd1,
    OP_BOX   = 2'd2,
    OP_POINT = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_CN,
    SEL_HN,
    SEL_DF,
    SEL_ND,
    SEL_NSL,
    SEL_NSH,
    SEL_SQ
  } sel_e;

  typedef struct packed {
    logic       lat_in;
    logic [1:0] row;
    logic [2:0] plane;
    logic       raw_we;
    sel_e       sel;
    logic [1:0] k;
    logic       acc_init;
    logic       sq_start;
    logic       sq_step;
    logic       div_start;
    logic       div_step;
    logic       pl_we;
    logic       res_upd;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic len_ok;
  } sts_t;

endpackage

// ===== hw/rtl/vfc_if.sv =====
// ----------------------------------------------------------------------------
// vfc channel interfaces
// Valid/ready channels for test items and for answers.
// ----------------------------------------------------------------------------
interface vfc_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [3:0]          elem_index;
  logic signed [31:0]  elem_value;
  logic signed [31:0]  center_x;
  logic signed [31:0]  center_y;
  logic signed [31:0]  center_z;
  logic [30:0]         half_x;
  logic [30:0]         half_y;
  logic [30:0]         half_z;

  modport source (
    output valid, opcode, elem_index, elem_value,
           center_x, center_y, center_z, half_x, half_y, half_z,
    input  ready
  );
  modport sink (
    input  valid, opcode, elem_index, elem_value,
           center_x, center_y, center_z, half_x, half_y, half_z,
    output ready
  );
endinterface

interface vfc_out_if;
  logic valid;
  logic ready;
  logic answer_valid;
  logic inside_res;

  modport source (output valid, answer_valid, inside_res, input ready);
  modport sink (input valid, answer_valid, inside_res, output ready);
endinterface

// ===== hw/rtl/vfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// vfc_ctrl: sequencer
// Walks planes and steps for build, box and point operations.
// ----------------------------------------------------------------------------
module vfc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  vfc_pkg::opcode_e      in_opcode_i,
  input  logic                  out_free_i,
  input  vfc_pkg::sts_t         sts_i,
  output logic                  in_ready_o,
  output vfc_pkg::cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAW,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_WR,
    ST_TEST,
    ST_CHECK,
    ST_DONE
  } state_e;

  state_e                     state_q;
  vfc_pkg::opcode_e           op_q;
  logic [2:0]                 plane_q;
  logic [1:0]                 row_q;
  logic [vfc_pkg::CNT_W-1:0]  cnt_q;
  logic [vfc_pkg::CNT_W-1:0]  test_last;

  assign test_last = (op_q == vfc_pkg::OP_BOX) ? vfc_pkg::CNT_W'(7) : vfc_pkg::CNT_W'(12);
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o       = '0;
    cmd_o.sel   = vfc_pkg::SEL_NONE;
    cmd_o.plane = plane_q;
    cmd_o.row   = row_q;
    unique case (state_q)
      ST_IDLE: cmd_o.lat_in = in_valid_i;
      ST_RAW: begin
        cmd_o.raw_we = 1'b1;
        cmd_o.row    = cnt_q[1:0];
      end
      ST_SQ: begin
        cmd_o.acc_init = (cnt_q == '0);
        if (cnt_q < vfc_pkg::CNT_W'(3)) begin
          cmd_o.sel = vfc_pkg::SEL_SQ;
          cmd_o.k   = cnt_q[1:0];
        end
      end
      ST_SQRT: begin
        cmd_o.sq_start = (cnt_q == '0);
        cmd_o.sq_step  = (cnt_q != '0) && (cnt_q != vfc_pkg::CNT_W'(vfc_pkg::SQ_LAST));
      end
      ST_DIV: begin
        cmd_o.div_start = (cnt_q == '0);
        cmd_o.div_step  = (cnt_q != '0);
      end
      ST_WR: cmd_o.pl_we = 1'b1;
      ST_TEST: begin
        cmd_o.acc_init = (cnt_q == '0);
        if (op_q == vfc_pkg::OP_BOX) begin
          // per axis: center term then half-extent term, then d
          if (cnt_q < vfc_pkg::CNT_W'(6)) begin
            cmd_o.k   = cnt_q[2:1];
            cmd_o.sel = cnt_q[0] ? vfc_pkg::SEL_HN : vfc_pkg::SEL_CN;
          end else if (cnt_q == vfc_pkg::CNT_W'(6)) begin
            cmd_o.sel = vfc_pkg::SEL_DF;
          end
        end else if (cnt_q < vfc_pkg::CNT_W'(12)) begin
          // per axis: n*d, gap while sk settles, low and high halves of n*sk
          cmd_o.k = cnt_q[3:2];
          case (cnt_q[1:0])
            2'd0:    cmd_o.sel = vfc_pkg::SEL_ND;
            2'd2:    cmd_o.sel = vfc_pkg::SEL_NSL;
            2'd3:    cmd_o.sel = vfc_pkg::SEL_NSH;
            default: cmd_o.sel = vfc_pkg::SEL_NONE;
          endcase
        end
      end
      ST_CHECK: cmd_o.res_upd = 1'b1;
      ST_DONE:  cmd_o.out_load = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= vfc_pkg::OP_WRITE;
      plane_q <= '0;
      row_q   <= '0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q    <= in_opcode_i;
            plane_q <= '0;
            row_q   <= '0;
            cnt_q   <= '0;
            unique case (in_opcode_i)
              vfc_pkg::OP_WRITE: state_q <= ST_DONE;
              vfc_pkg::OP_BUILD: state_q <= ST_RAW;
              default:           state_q <= ST_TEST;
            endcase
          end
        end
        ST_RAW: begin
          if (cnt_q == vfc_pkg::CNT_W'(3)) begin
            cnt_q   <= '0;
            state_q <= ST_SQ;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_SQ: begin
          if (cnt_q == vfc_pkg::CNT_W'(3)) begin
            cnt_q   <= '0;
            state_q <= ST_SQRT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_SQRT: begin
          if (cnt_q == vfc_pkg::CNT_W'(vfc_pkg::SQ_LAST)) begin
            cnt_q   <= '0;
            row_q   <= '0;
            state_q <= sts_i.len_ok ? ST_DIV : ST_WR;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DIV: begin
          if (cnt_q == vfc_pkg::CNT_W'(vfc_pkg::DVD_W)) begin
            cnt_q   <= '0;
            state_q <= ST_WR;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_WR: begin
          cnt_q <= '0;
          if (row_q == 2'd3) begin
            row_q <= '0;
            if (plane_q == 3'd5) begin
              state_q <= ST_DONE;
            end else begin
              plane_q <= plane_q + 1'b1;
              state_q <= ST_RAW;
            end
          end else begin
            row_q   <= row_q + 1'b1;
            state_q <= sts_i.len_ok ? ST_DIV : ST_WR;
          end
        end
        ST_TEST: begin
          if (cnt_q == test_last) begin
            cnt_q   <= '0;
            state_q <= ST_CHECK;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_CHECK: begin
          if (plane_q == 3'd5) begin
            state_q <= ST_DONE;
          end else begin
            plane_q <= plane_q + 1'b1;
            state_q <= ST_TEST;
          end
        end
        ST_DONE: begin
          if (out_free_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/vfc_dp.sv =====
// ----------------------------------------------------------------------------
// vfc_dp: datapath
// Matrix and plane stores, shared multiplier with accumulator, square root
// and divider units that resolve one bit per cycle.
// ----------------------------------------------------------------------------
module vfc_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vfc_pkg::cmd_t        cmd_i,
  input  vfc_pkg::opcode_e     opcode_i,
  input  logic [3:0]           elem_index_i,
  input  logic signed [31:0]   elem_value_i,
  input  logic signed [31:0]   center_x_i,
  input  logic signed [31:0]   center_y_i,
  input  logic signed [31:0]   center_z_i,
  input  logic [30:0]          half_x_i,
  input  logic [30:0]          half_y_i,
  input  logic [30:0]          half_z_i,
  output vfc_pkg::sts_t        sts_o,
  output logic                 ans_o,
  output logic                 inside_o
);

  localparam int unsigned W   = vfc_pkg::W;
  localparam int unsigned MW  = vfc_pkg::MW;
  localparam int unsigned PW  = vfc_pkg::PW;
  localparam int unsigned AW  = vfc_pkg::ACC_W;
  localparam int unsigned SW  = vfc_pkg::SQ_W;
  localparam int unsigned DW  = vfc_pkg::DVD_W;

  logic signed [W-1:0]   mat_q [4][4];
  logic signed [W-1:0]   pl_q  [6][4];
  logic signed [W-1:0]   raw_q [4];
  logic signed [W-1:0]   c_q   [3];
  logic [vfc_pkg::HW-1:0] h_q  [3];
  vfc_pkg::opcode_e      op_q;
  logic                  inside_q;

  logic signed [PW-1:0]  prod_q;
  logic                  pv_q, psh_q, psk_q;
  logic [1:0]            pk_q;
  logic signed [AW-1:0]  acc_q;
  logic signed [63:0]    sk_q;

  logic [SW-1:0]         sq_n_q, sq_res_q, sq_bit_q;
  logic [DW-1:0]         quo_q;
  logic [W-1:0]          rem_q;

  // plane row and matrix row reads
  logic signed [W-1:0]   n_sel, d_sel, m_a, m_b;
  logic signed [MW-1:0]  n_ext, n_abs, op_a, op_b;
  logic signed [W:0]     raw_sum;
  logic signed [W-1:0]   raw_sat;
  logic signed [AW-1:0]  prod_ext, prod_sh, acc_init_v;
  logic [SW-1:0]         sq_t;
  logic [W:0]            dv_trial;
  logic                  dv_ge;
  logic [W-1:0]          len, raw_mag, wr_val;
  logic signed [W-1:0]   raw_r;

  assign n_sel = pl_q[cmd_i.plane][cmd_i.k];
  assign d_sel = pl_q[cmd_i.plane][3];
  assign n_ext = {n_sel[W-1], n_sel};
  assign n_abs = n_ext[MW-1] ? -n_ext : n_ext;

  assign m_a = mat_q[cmd_i.row][3];
  assign m_b = mat_q[cmd_i.row][cmd_i.plane[2:1]];
  assign raw_sum = cmd_i.plane[0] ? ({m_a[W-1], m_a} + {m_b[W-1], m_b})
                                  : ({m_a[W-1], m_a} - {m_b[W-1], m_b});
  always_comb begin
    if (raw_sum[W] != raw_sum[W-1]) begin
      raw_sat = raw_sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      raw_sat = raw_sum[W-1:0];
    end
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.sel)
      vfc_pkg::SEL_CN: begin
        op_a = MW'(c_q[cmd_i.k]);
        op_b = n_ext;
      end
      vfc_pkg::SEL_HN: begin
        op_a = {2'b00, h_q[cmd_i.k]};
        op_b = n_abs;
      end
      vfc_pkg::SEL_DF: begin
        op_a = MW'(d_sel);
        op_b = vfc_pkg::ONE_Q;
      end
      vfc_pkg::SEL_ND: begin
        op_a = n_ext;
        op_b = MW'(d_sel);
      end
      vfc_pkg::SEL_NSL: begin
        op_a = n_ext;
        op_b = {1'b0, sk_q[31:0]};
      end
      vfc_pkg::SEL_NSH: begin
        op_a = n_ext;
        op_b = MW'($signed(sk_q[63:32]));
      end
      vfc_pkg::SEL_SQ: begin
        op_a = MW'(raw_q[cmd_i.k]);
        op_b = MW'(raw_q[cmd_i.k]);
      end
      default: ;
    endcase
  end

  assign prod_ext   = AW'(prod_q);
  assign prod_sh    = psh_q ? (prod_ext <<< 32) : prod_ext;
  assign acc_init_v = (op_q == vfc_pkg::OP_POINT) ? vfc_pkg::PT_EPS_ACC : '0;

  assign sq_t = sq_res_q + sq_bit_q;
  assign len  = sq_res_q[W-1:0];
  assign sts_o.len_ok = (sq_res_q > SW'(vfc_pkg::LEN_EPS));

  assign dv_trial = {rem_q, quo_q[DW-1]};
  assign dv_ge    = (dv_trial >= {1'b0, len});

  assign raw_r   = raw_q[cmd_i.row];
  assign raw_mag = raw_r[W-1] ? W'(-raw_r) : W'(raw_r);

  // signed saturation of the quotient, or the raw value for short normals
  always_comb begin
    if (!sts_o.len_ok) begin
      wr_val = raw_r;
    end else if (raw_r[W-1]) begin
      wr_val = (quo_q > (DW'(1) << (W - 1))) ? {1'b1, {(W-1){1'b0}}} : -quo_q[W-1:0];
    end else begin
      wr_val = (quo_q > ((DW'(1) << (W - 1)) - 1'b1)) ? {1'b0, {(W-1){1'b1}}}
                                                       : quo_q[W-1:0];
    end
  end

  assign ans_o    = (op_q == vfc_pkg::OP_BOX) || (op_q == vfc_pkg::OP_POINT);
  assign inside_o = ans_o && inside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) mat_q[r][c] <= '0;
      end
      for (int p = 0; p < 6; p++) begin
        for (int c = 0; c < 4; c++) pl_q[p][c] <= '0;
      end
      op_q     <= vfc_pkg::OP_WRITE;
      inside_q <= 1'b0;
      pv_q     <= 1'b0;
      psh_q    <= 1'b0;
      psk_q    <= 1'b0;
    end else begin
      if (cmd_i.lat_in) begin
        op_q     <= opcode_i;
        inside_q <= 1'b1;
        if (opcode_i == vfc_pkg::OP_WRITE) begin
          mat_q[elem_index_i[3:2]][elem_index_i[1:0]] <= elem_value_i;
        end
      end
      if (cmd_i.res_upd) inside_q <= inside_q & ~acc_q[AW-1];
      if (cmd_i.pl_we) pl_q[cmd_i.plane][cmd_i.row] <= wr_val;
      pv_q  <= (cmd_i.sel != vfc_pkg::SEL_NONE) && (cmd_i.sel != vfc_pkg::SEL_ND);
      psh_q <= (cmd_i.sel == vfc_pkg::SEL_NSH);
      psk_q <= (cmd_i.sel == vfc_pkg::SEL_ND);
    end
  end

  // payload, raw plane, multiplier, accumulator, square root and divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_in) begin
      c_q[0] <= center_x_i;
      c_q[1] <= center_y_i;
      c_q[2] <= center_z_i;
      h_q[0] <= half_x_i;
      h_q[1] <= half_y_i;
      h_q[2] <= half_z_i;
    end
    if (cmd_i.raw_we) raw_q[cmd_i.row] <= raw_sat;
    prod_q <= op_a * op_b;
    pk_q   <= cmd_i.k;
    if (cmd_i.acc_init) begin
      acc_q <= acc_init_v;
    end else if (pv_q) begin
      acc_q <= acc_q + prod_sh;
    end
    if (psk_q) sk_q <= 64'(prod_q) + (64'(c_q[pk_q]) <<< vfc_pkg::FRAC_BITS);
    if (cmd_i.sq_start) begin
      sq_n_q   <= acc_q[SW-1:0];
      sq_res_q <= '0;
      sq_bit_q <= SW'(1) << (SW - 2);
    end else if (cmd_i.sq_step) begin
      if (sq_n_q >= sq_t) begin
        sq_n_q   <= sq_n_q - sq_t;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
    if (cmd_i.div_start) begin
      quo_q <= DW'(raw_mag) << vfc_pkg::FRAC_BITS;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= dv_ge ? W'(dv_trial - {1'b0, len}) : dv_trial[W-1:0];
      quo_q <= {quo_q[DW-2:0], dv_ge};
    end
  end

endmodule

// ===== hw/rtl/view_frustum_cull_test_top.sv =====
// ----------------------------------------------------------------------------
// view_frustum_cull_test_top: frustum plane build and cull tests
// Sequencer, datapath and the answer output register.
// ----------------------------------------------------------------------------
// matrix write: goes straight to the done state, then the answer is loaded into the output register
// box and point tests: six planes through one multiplier
// plane build: one-bit-per-cycle square root and divide
// one item in flight; the next is taken while the answer waits in the output register
// reset clears matrix and plane stores to zero, no clearing pass
module view_frustum_cull_test_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  vfc_in_if.sink     in_i,
  vfc_out_if.source  out_o
);

  vfc_pkg::cmd_t ctl_cmd;
  vfc_pkg::sts_t dp_sts;
  logic          out_valid_q, ans_q, inside_q;
  logic          dp_ans, dp_inside, out_free;

  assign out_free = !out_valid_q || out_o.ready;

  vfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (vfc_pkg::opcode_e'(in_i.opcode)),
    .out_free_i  (out_free),
    .sts_i       (dp_sts),
    .in_ready_o  (in_i.ready),
    .cmd_o       (ctl_cmd)
  );

  vfc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctl_cmd),
    .opcode_i     (vfc_pkg::opcode_e'(in_i.opcode)),
    .elem_index_i (in_i.elem_index),
    .elem_value_i (in_i.elem_value),
    .center_x_i   (in_i.center_x),
    .center_y_i   (in_i.center_y),
    .center_z_i   (in_i.center_z),
    .half_x_i     (in_i.half_x),
    .half_y_i     (in_i.half_y),
    .half_z_i     (in_i.half_z),
    .sts_o        (dp_sts),
    .ans_o        (dp_ans),
    .inside_o     (dp_inside)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_cmd.out_load) begin
      ans_q    <= dp_ans;
      inside_q <= dp_inside;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.answer_valid = ans_q;
  assign out_o.inside_res   = inside_q;

  // one item at a time: no second transfer straight after the first
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while an item is in flight");

  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctl_cmd.out_load))
    else $error("answer raised without a load");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd.out_load |-> out_free)
    else $error("answer overwritten before transfer");

  a_inside_needs_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.answer_valid |-> !out_o.inside_res)
    else $error("inside flag set on a non-test answer");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// frustum cull bench
// Drives matrix writes, plane builds and box/point tests through the item
// channel and checks every answer against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int TIMEOUT_CYCLES = 2_000_000;

  typedef struct packed {
    logic       answer_valid;
    logic       inside_res;
  } answer_t;

  typedef struct {
    vfc_pkg::opcode_e   op;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] cx, cy, cz;
    logic [30:0]        hx, hy, hz;
    logic               known;
    logic               exp_inside;
  } item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  vfc_in_if  in_ch ();
  vfc_out_if out_ch ();

  view_frustum_cull_test_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic signed [31:0] mat_q [16];
  logic signed [31:0] pln_q [24];
  answer_t            answers_q [$];
  int                 errors = 0;
  int                 cycle = 0;
  int                 n_box = 0, n_point = 0, n_build = 0, n_out = 0;
  int                 n_box_in = 0, n_point_in = 0;
  bit                 calm = 1'b0;

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic derive_planes();
    logic signed [63:0] raw [4];
    logic signed [63:0] a, b, v;
    logic [63:0] sumsq, len, mag, q;
    for (int i = 0; i < 3; i++) begin
      for (int s = 0; s < 2; s++) begin
        sumsq = 0;
        for (int r = 0; r < 4; r++) begin
          a = mat_q[4*r+3];
          b = mat_q[4*r+i];
          raw[r] = clamp32(s ? a + b : a - b);
        end
        for (int r = 0; r < 3; r++) sumsq = sumsq + 64'(raw[r] * raw[r]);
        len = root64(sumsq);
        for (int r = 0; r < 4; r++) begin
          v = raw[r];
          if (len > 64'(vfc_pkg::LEN_EPS)) begin
            mag = v < 0 ? -v : v;
            q = (mag << vfc_pkg::FRAC_BITS) / len;
            v = raw[r] < 0 ? -$signed(q) : $signed(q);
          end
          pln_q[4*(2*i+s)+r] = clamp32(v);
        end
      end
    end
  endtask

  function automatic logic box_clear(item_t it);
    logic signed [159:0] acc;
    logic signed [63:0] c [3], h [3], n;
    c = '{it.cx, it.cy, it.cz};
    h = '{64'(it.hx), 64'(it.hy), 64'(it.hz)};
    for (int p = 0; p < 6; p++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        n = pln_q[4*p+k];
        acc = acc + 160'(c[k]) * 160'(n) + 160'(h[k]) * 160'(n < 0 ? -n : n);
      end
      acc = acc + 160'(pln_q[4*p+3]) * (160'sd1 <<< vfc_pkg::FRAC_BITS);
      if (acc < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic point_clear(item_t it);
    logic signed [159:0] acc;
    logic signed [63:0] c [3], n, d, sk;
    c = '{it.cx, it.cy, it.cz};
    for (int p = 0; p < 6; p++) begin
      acc = 0;
      d = pln_q[4*p+3];
      for (int k = 0; k < 3; k++) begin
        n = pln_q[4*p+k];
        sk = n * d + (c[k] <<< vfc_pkg::FRAC_BITS);
        acc = acc + 160'(n) * 160'(sk);
      end
      acc = acc + (160'(vfc_pkg::PT_EPS) <<< (2 * vfc_pkg::FRAC_BITS));
      if (acc < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic apply_item(item_t it);
    answer_t a;
    a = '0;
    case (it.op)
      vfc_pkg::OP_WRITE: mat_q[it.idx] = it.val;
      vfc_pkg::OP_BUILD: begin
        derive_planes();
        n_build++;
      end
      vfc_pkg::OP_BOX: begin
        a.answer_valid = 1'b1;
        a.inside_res = box_clear(it);
        n_box_in += a.inside_res;
        n_box++;
      end
      default: begin
        a.answer_valid = 1'b1;
        a.inside_res = point_clear(it);
        n_point_in += a.inside_res;
        n_point++;
      end
    endcase
    if (it.known && a.inside_res !== it.exp_inside) begin
      $error("directed row inside_res: expected %0b, predictor gives %0b",
             it.exp_inside, a.inside_res);
      errors++;
    end
    answers_q.push_back(a);
  endtask

  task automatic send_item(item_t it);
    while (!calm && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= it.op;
    in_ch.elem_index <= it.idx;
    in_ch.elem_value <= it.val;
    in_ch.center_x   <= it.cx;
    in_ch.center_y   <= it.cy;
    in_ch.center_z   <= it.cz;
    in_ch.half_x     <= it.hx;
    in_ch.half_y     <= it.hy;
    in_ch.half_z     <= it.hz;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    apply_item(it);
  endtask

  function automatic item_t mk(vfc_pkg::opcode_e op, logic [3:0] idx = 0,
                               logic signed [31:0] val = 0,
                               logic signed [31:0] cx = 0, logic signed [31:0] cy = 0,
                               logic signed [31:0] cz = 0, logic [30:0] hx = 0,
                               logic [30:0] hy = 0, logic [30:0] hz = 0,
                               logic known = 0, logic exp_inside = 0);
    item_t it;
    it.op = op; it.idx = idx; it.val = val;
    it.cx = cx; it.cy = cy; it.cz = cz;
    it.hx = hx; it.hy = hy; it.hz = hz;
    it.known = known; it.exp_inside = exp_inside;
    return it;
  endfunction

  function automatic logic signed [31:0] rnd_q(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(32'h60000)) - 32'sh30000;
      default: return $signed($urandom_range(32'h2000000)) - 32'sh1000000;
    endcase
  endfunction

  function automatic item_t rnd_test();
    item_t it;
    int m;
    m = $urandom_range(9) < 2 ? 0 : 2;
    it = mk($urandom_range(1) ? vfc_pkg::OP_BOX : vfc_pkg::OP_POINT, 4'($urandom), $urandom,
            rnd_q(m), rnd_q(m), rnd_q(m));
    it.hx = $urandom_range(9) == 0 ? 31'($urandom) : 31'($urandom_range(32'h200000));
    it.hy = $urandom_range(9) == 0 ? 31'($urandom) : 31'($urandom_range(32'h200000));
    it.hz = $urandom_range(9) == 0 ? 31'($urandom) : 31'($urandom_range(32'h200000));
    return it;
  endfunction

  // answer side: random stalls, compare against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_out++;
        if (answers_q.size() == 0) begin
          $error("answer transfer with nothing expected");
          errors++;
        end else begin
          if (out_ch.answer_valid !== answers_q[0].answer_valid) begin
            $error("answer_valid: expected %0b, got %0b",
                   answers_q[0].answer_valid, out_ch.answer_valid);
            errors++;
          end
          if (out_ch.inside_res !== answers_q[0].inside_res) begin
            $error("inside_res: expected %0b, got %0b",
                   answers_q[0].inside_res, out_ch.inside_res);
            errors++;
          end
          void'(answers_q.pop_front());
        end
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk_i) begin
    cycle++;
    if (cycle > TIMEOUT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    item_t dir [$];
    item_t it;
    int r;
    in_ch.valid = 1'b0;
    in_ch.opcode = vfc_pkg::OP_WRITE;
    in_ch.elem_index = '0;
    in_ch.elem_value = '0;
    in_ch.center_x = '0;
    in_ch.center_y = '0;
    in_ch.center_z = '0;
    in_ch.half_x = '0;
    in_ch.half_y = '0;
    in_ch.half_z = '0;
    for (int i = 0; i < 16; i++) mat_q[i] = 0;
    for (int i = 0; i < 24; i++) pln_q[i] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero planes after reset: everything is inside
    dir.push_back(mk(vfc_pkg::OP_BOX, 0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                     31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 1, 1));
    dir.push_back(mk(vfc_pkg::OP_POINT, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                     0, 0, 0, 1, 1));
    // build on an all-zero matrix leaves planes zero (length below threshold)
    dir.push_back(mk(vfc_pkg::OP_BUILD, 15, 32'sh7fffffff));
    dir.push_back(mk(vfc_pkg::OP_POINT, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                     0, 0, 0, 1, 1));
    // identity matrix: unit cube frustum
    for (int i = 0; i < 16; i++)
      dir.push_back(mk(vfc_pkg::OP_WRITE, 4'(i), (i % 5 == 0) ? 32'sh10000 : 32'sh0));
    dir.push_back(mk(vfc_pkg::OP_BUILD));
    dir.push_back(mk(vfc_pkg::OP_BOX, 0, 0, 0, 0, 0, 31'h8000, 31'h8000, 31'h8000, 1, 1));
    dir.push_back(mk(vfc_pkg::OP_BOX, 0, 0, 32'sh50000, 0, 0, 31'h10000, 0, 0, 1, 0));
    dir.push_back(mk(vfc_pkg::OP_POINT, 0, 0, 32'sh8000, 0, 0, 0, 0, 0));
    dir.push_back(mk(vfc_pkg::OP_POINT, 0, 0, 32'sh7fffffff, 0, 0, 0, 0, 0, 1, 0));
    // extreme elements saturate the raw planes
    dir.push_back(mk(vfc_pkg::OP_WRITE, 3, 32'sh7fffffff));
    dir.push_back(mk(vfc_pkg::OP_WRITE, 0, 32'sh80000000));
    dir.push_back(mk(vfc_pkg::OP_BUILD));
    dir.push_back(mk(vfc_pkg::OP_BOX, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                     31'h7fffffff, 0, 31'h7fffffff));
    dir.push_back(mk(vfc_pkg::OP_POINT, 0, 0, 32'sh7fffffff, 32'sh80000000, 0));

    foreach (dir[i]) send_item(dir[i]);

    // mostly coherent frustums with random tests, some raw noise
    for (int n = 0; n < 840; n++) begin
      calm = (n >= 300 && n < 420);
      if (n == 540) begin
        in_ch.valid <= 1'b0;
        while (answers_q.size() != 0) @(posedge clk_i);
      end
      r = $urandom_range(99);
      if (n % 60 == 0) begin
        for (int i = 0; i < 16; i++) begin
          it = mk(vfc_pkg::OP_WRITE, 4'(i),
                  $urandom_range(3) == 0 ? 32'($urandom) : rnd_q(1));
          if (i % 5 == 0 && $urandom_range(3) != 0) it.val = 32'sh10000 + rnd_q(1) / 4;
          send_item(it);
        end
        send_item(mk(vfc_pkg::OP_BUILD));
      end else if (r < 4) begin
        send_item(mk(vfc_pkg::OP_WRITE, 4'($urandom),
                     $urandom_range(1) ? 32'($urandom) : rnd_q(1)));
      end else if (r < 6) begin
        send_item(mk(vfc_pkg::OP_BUILD, 4'($urandom), $urandom));
      end else begin
        send_item(rnd_test());
      end
    end

    in_ch.valid <= 1'b0;
    while (answers_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d builds, %0d box tests (%0d inside), %0d point tests (%0d inside)",
             n_build, n_box, n_box_in, n_point, n_point_in);
    $display("%0d answers checked, %0d mismatches", n_out, errors);
    if (errors == 0 && answers_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/vfc_pkg.sv
hw/rtl/vfc_if.sv
hw/rtl/vfc_ctrl.sv
hw/rtl/vfc_dp.sv
hw/rtl/view_frustum_cull_test_top.sv
bench/testbench.sv
